FILE: rtl/core/vtpg_pkg.sv
package vtpg_pkg;

  // Field and register widths
  localparam int unsigned ColW     = 12;
  localparam int unsigned RowW     = 9;
  localparam int unsigned PixW     = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;

  // Column gradient divider: numerator column*255, 8-bit quotient
  localparam int unsigned NumW = ColW + 8;
  localparam int unsigned QuoW = 8;

  localparam int unsigned FRAME_HEIGHT_DEFAULT = 480;

  // Pattern modes; the unused code falls back to the checkerboard
  localparam logic [ModeW-1:0] MODE_CHECKER = 2'd0;
  localparam logic [ModeW-1:0] MODE_BANDS   = 2'd1;
  localparam logic [ModeW-1:0] MODE_PROBE   = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_PATTERN_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_WIDTH = 1'b1;

  localparam logic [ModeW-1:0] MODE_RESET  = MODE_CHECKER;
  localparam logic [ColW-1:0]  WIDTH_RESET = 12'd720;

  // Probe border that wins for a pixel
  typedef enum logic [2:0] {
    BRD_NONE,
    BRD_TOP,
    BRD_BOTTOM,
    BRD_LEFT,
    BRD_RIGHT
  } border_e;

  // Per-pixel control carried down the pipeline
  typedef struct packed {
    logic    pad;
    logic    probe;
    logic    tile;
    border_e border;
  } pix_info_t;

  function automatic logic [PixW-1:0] pack565(input logic [7:0] r,
                                              input logic [7:0] g,
                                              input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

FILE: rtl/core/vtpg_pattern.sv
module vtpg_pattern import vtpg_pkg::*; #(
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEFAULT
) (
  input  logic [ColW-1:0]  column_i,
  input  logic [RowW-1:0]  row_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [ColW-1:0]  width_i,
  output logic [PixW-1:0]  pix_o,
  output pix_info_t        info_o
);

  localparam logic [ColW-1:0] BotStart = ColW'(FRAME_HEIGHT - 32);

  logic [7:0] x, y, yl;
  logic [4:0] xy_lo;
  logic [7:0] band;
  logic [7:0] r, g, b;
  logic       right_en;

  assign x     = column_i[7:0];
  assign y     = row_i[7:0];
  assign yl    = {row_i[6:0], 1'b0};
  assign xy_lo = column_i[4:0] + row_i[4:0];
  assign band  = {6'd0, xy_lo[4:3]};

  // Byte formulas of the checkerboard and band modes, all mod 256
  always_comb begin
    if (mode_i == MODE_BANDS) begin
      r = x * 8'd11 + y * 8'd5 + band * 8'd37;
      g = 8'd255 - x * 8'd3 + y * 8'd13;
      b = (x ^ yl) + band * 8'd61;
    end else if (column_i[4] ^ row_i[4]) begin
      r = x * 8'd5 + y * 8'd3;
      g = x ^ (y * 8'd7);
      b = 8'd255 - y * 8'd5 + x;
    end else begin
      r = 8'd255 - x * 8'd7 + y;
      g = y * 8'd9 + x * 8'd2;
      b = x * 8'd3 - y * 8'd11;
    end
  end

  assign pix_o = pack565(r, g, b);

  // Probe: right border wins over left, left over bottom, bottom over top
  assign right_en = (width_i >= ColW'(32)) && (column_i >= width_i - ColW'(32));

  always_comb begin
    info_o.pad   = column_i >= width_i;
    info_o.probe = mode_i == MODE_PROBE;
    info_o.tile  = column_i[ColW-1:4] != {{(ColW-RowW){1'b0}}, row_i[RowW-1:4]};
    priority if (right_en) begin
      info_o.border = BRD_RIGHT;
    end else if (column_i < ColW'(32)) begin
      info_o.border = BRD_LEFT;
    end else if (ColW'(row_i) >= BotStart) begin
      info_o.border = BRD_BOTTOM;
    end else if (row_i < RowW'(32)) begin
      info_o.border = BRD_TOP;
    end else begin
      info_o.border = BRD_NONE;
    end
  end

endmodule

FILE: rtl/core/vtpg_div_stage.sv
module vtpg_div_stage import vtpg_pkg::*; #(
  parameter int unsigned STEP = 7
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [ColW-1:0] div_i,
  input  logic [NumW-1:0] rem_i,
  input  logic [QuoW-1:0] quo_i,
  output logic [NumW-1:0] rem_o,
  output logic [QuoW-1:0] quo_o
);

  logic [NumW-1:0] sh_hi, sh_lo;
  logic [NumW-1:0] rem_m, rem_d;
  logic [QuoW-1:0] quo_m, quo_d;
  logic [NumW-1:0] rem_q;
  logic [QuoW-1:0] quo_q;

  assign sh_hi = NumW'(div_i) << STEP;
  assign sh_lo = NumW'(div_i) << (STEP - 1);

  // Two restoring steps: quotient bits STEP and STEP-1
  always_comb begin
    rem_m = rem_i;
    quo_m = quo_i;
    if (rem_i >= sh_hi) begin
      rem_m       = rem_i - sh_hi;
      quo_m[STEP] = 1'b1;
    end
    rem_d = rem_m;
    quo_d = quo_m;
    if (rem_m >= sh_lo) begin
      rem_d         = rem_m - sh_lo;
      quo_d[STEP-1] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

FILE: rtl/core/vtpg_row_scale.sv
module vtpg_row_scale import vtpg_pkg::*; #(
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEFAULT
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RowW-1:0] row_i,
  output logic [7:0]      grad_o
);

  // row*255 / (FRAME_HEIGHT-1) by reciprocal, then one correction step
  localparam int unsigned NumRW   = RowW + 8;
  localparam int unsigned RowDiv  = FRAME_HEIGHT - 1;
  localparam int unsigned Recip   = (2 ** NumRW) / RowDiv;
  localparam int unsigned RecipW  = $clog2(Recip + 1);
  localparam int unsigned ProdW   = NumRW + RecipW;
  localparam logic [ProdW-1:0] MulC = ProdW'(255 * Recip);
  localparam logic [NumRW-1:0] DivC = NumRW'(RowDiv);

  logic [NumRW-1:0]  num_a_d, num_a_q, num_b_q;
  logic [ProdW-1:0]  prod_a_d, prod_a_q;
  logic [RecipW-1:0] qest_b_d, qest_b_q;
  logic [NumRW-1:0]  qd_b_d, qd_b_q;
  logic [NumRW-1:0]  rem_c;
  logic [RecipW-1:0] quo_c;
  logic [7:0]        grad_c_q, grad_d_q, grad_e_q;

  assign num_a_d  = {row_i, 8'd0} - NumRW'(row_i);
  assign prod_a_d = ProdW'(row_i) * MulC;

  assign qest_b_d = prod_a_q[ProdW-1:NumRW];
  assign qd_b_d   = NumRW'(qest_b_d) * DivC;

  // estimate is low by at most one
  assign rem_c = num_b_q - qd_b_q;
  assign quo_c = (rem_c >= DivC) ? qest_b_q + RecipW'(1) : qest_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_a_q  <= num_a_d;
      prod_a_q <= prod_a_d;
      num_b_q  <= num_a_q;
      qest_b_q <= qest_b_d;
      qd_b_q   <= qd_b_d;
      grad_c_q <= 8'(quo_c);
      grad_d_q <= grad_c_q;
      grad_e_q <= grad_d_q;
    end
  end

  assign grad_o = grad_e_q;

endmodule

FILE: rtl/core/video_test_pattern_generator_unit.sv
// Channel    Dir  Fields (low bit up)              Transaction when
// s_axis     in   tdata: column[11:0] row[20:12]   s_axis_tvalid && s_axis_tready
// m_axis     out  tdata: pixel[15:0] (RGB565)      m_axis_tvalid && m_axis_tready
// cfg        in   index 0 pattern_mode, 1 width    cfg_we_i high
//
// One pixel per cycle sustained while m_axis does not stall; output valid follows the
// input transaction through seven register stages (input register, pattern stage,
// four column-divider stages, output register). The column gradient divider
// retires two quotient bits per stage. Reset clears the valid bits and the configuration
// registers (mode 0, width 720). A stall on m_axis freezes the whole pipeline;
// s_axis_tready drops only while the output register is full and not taken.
module video_test_pattern_generator_unit import vtpg_pkg::*; #(
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // column[11:0], row[20:12], zero pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata,   // pixel[15:0]
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NStage = 7;

  logic [ModeW-1:0] mode_q;
  logic [ColW-1:0]  width_q;
  logic [ColW-1:0]  div_w;

  logic             en;
  logic [NStage:1]  vld_q;

  logic [ColW-1:0]  col1_q;
  logic [RowW-1:0]  row1_q;

  logic [PixW-1:0]  pix_s1;
  pix_info_t        info_s1;
  logic [PixW-1:0]  pix_q  [2:6];
  pix_info_t        info_q [2:6];

  logic [NumW-1:0]  num2_q;
  logic [NumW-1:0]  rem3, rem4, rem5, rem6;
  logic [QuoW-1:0]  quo3, quo4, quo5, quo6;
  logic [7:0]       grad6;

  logic [7:0]       pr, pg, pb;
  logic [PixW-1:0]  out_d, out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      width_q <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_MODE: mode_q  <= cfg_data_i[ModeW-1:0];
        CFG_ACTIVE_WIDTH: width_q <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  assign div_w = width_q - ColW'(1);

  // Whole pipeline moves unless the output register is held
  assign en            = !vld_q[NStage] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStage-1:1], s_axis_tvalid};
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      col1_q <= s_axis_tdata[ColW-1:0];
      row1_q <= s_axis_tdata[ColW+RowW-1:ColW];
    end
  end

  vtpg_pattern #(
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_pattern (
    .column_i(col1_q),
    .row_i   (row1_q),
    .mode_i  (mode_q),
    .width_i (width_q),
    .pix_o   (pix_s1),
    .info_o  (info_s1)
  );

  // Stage 2..6: pattern results ride along with the divider
  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[2]  <= pix_s1;
      info_q[2] <= info_s1;
      num2_q    <= {col1_q, 8'd0} - NumW'(col1_q);
      for (int i = 3; i <= 6; i++) begin
        pix_q[i]  <= pix_q[i-1];
        info_q[i] <= info_q[i-1];
      end
    end
  end

  vtpg_div_stage #(.STEP(7)) u_div0 (
    .clk_i(clk_i), .en_i(en), .div_i(div_w),
    .rem_i(num2_q), .quo_i('0), .rem_o(rem3), .quo_o(quo3)
  );
  vtpg_div_stage #(.STEP(5)) u_div1 (
    .clk_i(clk_i), .en_i(en), .div_i(div_w),
    .rem_i(rem3), .quo_i(quo3), .rem_o(rem4), .quo_o(quo4)
  );
  vtpg_div_stage #(.STEP(3)) u_div2 (
    .clk_i(clk_i), .en_i(en), .div_i(div_w),
    .rem_i(rem4), .quo_i(quo4), .rem_o(rem5), .quo_o(quo5)
  );
  vtpg_div_stage #(.STEP(1)) u_div3 (
    .clk_i(clk_i), .en_i(en), .div_i(div_w),
    .rem_i(rem5), .quo_i(quo5), .rem_o(rem6), .quo_o(quo6)
  );

  vtpg_row_scale #(
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_row_scale (
    .clk_i (clk_i),
    .en_i  (en),
    .row_i (row1_q),
    .grad_o(grad6)
  );

  // Probe colors, borders last
  always_comb begin
    pr = grad6;
    pg = (width_q > ColW'(1)) ? quo6 : 8'd0;
    pb = info_q[6].tile ? 8'd255 : 8'd0;
    unique case (info_q[6].border)
      BRD_NONE:   ;
      BRD_TOP:    begin pr = 8'd255; pg = 8'd0;   pb = 8'd0;   end
      BRD_BOTTOM: begin pr = 8'd0;   pg = 8'd255; pb = 8'd0;   end
      BRD_LEFT:   begin pr = 8'd0;   pg = 8'd0;   pb = 8'd255; end
      BRD_RIGHT:  begin pr = 8'd255; pg = 8'd255; pb = 8'd0;   end
      default:    ;
    endcase
    if (info_q[6].pad) begin
      out_d = '0;
    end else if (info_q[6].probe) begin
      out_d = pack565(pr, pg, pb);
    end else begin
      out_d = pix_q[6];
    end
  end

  // Stage 7: output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vld_q[NStage];
  assign m_axis_tdata  = out_q;

  // remainder of the last divider stage is not needed
  logic unused_rem;
  assign unused_rem = ^rem6;

endmodule
